/* hw/rtl/rgbh_pkg.sv */
package rgbh_pkg;

	localparam int COUNT_BITS     = 24;
	localparam int BIN_COUNT      = 256;
	localparam int BIN_BITS       = $clog2(BIN_COUNT);
	localparam int TOTAL_BITS     = 32;
	localparam int OUT_COUNT_BITS = 24;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Per-bank controls for one pipeline step.
	typedef struct packed {
		logic advance;
		logic accept;
		logic s1_inc;
		logic s1_clr;
	} bank_ctrl_t;

endpackage

/* hw/rtl/rgbh_bank.sv */
module rgbh_bank
	import rgbh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  bank_ctrl_t            ctrl,
	input  logic [BIN_BITS-1:0]   addr,
	output logic [COUNT_BITS-1:0] count
);

	logic [COUNT_BITS-1:0] mem [BIN_COUNT];
	logic [BIN_COUNT-1:0]  vld_q;

	logic [COUNT_BITS-1:0] rd_data_s1;
	logic                  vld_rd_s1;
	logic [BIN_BITS-1:0]   addr_s1;

	logic                  fwd_vld_s2;
	logic [BIN_BITS-1:0]   fwd_addr_s2;
	logic [COUNT_BITS-1:0] fwd_val_s2;

	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] nxt;
	logic                  we;

	// The item in stage one read the memory at the same edge the previous item wrote it,
	// so that write is taken from the forwarding register instead.
	always_comb begin
		if (fwd_vld_s2 && (fwd_addr_s2 == addr_s1)) begin
			cur = fwd_val_s2;
		end else if (vld_rd_s1) begin
			cur = rd_data_s1;
		end else begin
			cur = '0;
		end
	end

	always_comb begin
		if (ctrl.s1_clr) begin
			nxt = '0;
		end else if (cur == COUNT_MAX) begin
			nxt = cur;
		end else begin
			nxt = cur + COUNT_BITS'(1);
		end
	end

	assign we    = ctrl.advance && (ctrl.s1_inc || ctrl.s1_clr);
	assign count = cur;

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			rd_data_s1 <= mem[addr];
			addr_s1    <= addr;
		end
		if (we) begin
			mem[addr_s1] <= nxt;
		end
		if (ctrl.advance) begin
			fwd_addr_s2 <= addr_s1;
			fwd_val_s2  <= nxt;
		end
	end

	// An entry whose valid bit is low has never been written since reset and reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			vld_rd_s1  <= 1'b0;
			fwd_vld_s2 <= 1'b0;
		end else begin
			if (ctrl.accept) begin
				vld_rd_s1 <= vld_q[addr];
			end
			if (we) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (ctrl.advance) begin
				fwd_vld_s2 <= we;
			end
		end
	end

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.s1_inc && ctrl.s1_clr))
		else $error("bank asked to increment and clear at once");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.s1_inc |-> ((nxt == cur) == (cur == COUNT_MAX)))
		else $error("bin increment did not saturate correctly");

	a_vld_set: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> vld_q[$past(addr_s1)])
		else $error("written bin not marked valid");

endmodule

/* hw/rtl/rgb_channel_histogram.sv */
// Channel | Valid     | Stall     | Payload
// in      | in_valid  | in_stall  | cmd, red_value, green_value, blue_value, read_bin
// out     | out_valid | out_stall | bin_index, red_count, green_count, blue_count, pixel_count
//
// One item is accepted per clock unless a result is stalled; read results are registered.
// Each bin update is a read of the bin memory, a saturating add and a write-back; a bin
// written by the item just ahead is forwarded, so repeated bins keep the full rate.
// Reset clears the per-bin valid bits at once; there is no clearing pass.
// While a result waits and out_stall is high, the pipeline holds and in_stall is raised.
module rgb_channel_histogram
	import rgbh_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic [7:0]                red_value,
	input  logic [7:0]                green_value,
	input  logic [7:0]                blue_value,
	input  logic [BIN_BITS-1:0]       read_bin,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [BIN_BITS-1:0]       bin_index,
	output logic [OUT_COUNT_BITS-1:0] red_count,
	output logic [OUT_COUNT_BITS-1:0] green_count,
	output logic [OUT_COUNT_BITS-1:0] blue_count,
	output logic [TOTAL_BITS-1:0]     pixel_count
);

	logic                      advance;
	logic                      accept;
	cmd_t                      cmd_in;

	logic                      valid_s1;
	cmd_t                      cmd_s1;
	logic [BIN_BITS-1:0]       bin_s1;

	logic                      inc_s1;
	logic                      clr_s1;
	logic                      rd_s1;

	logic [TOTAL_BITS-1:0]     pixel_total_q;

	logic                      out_valid_q;
	logic [BIN_BITS-1:0]       bin_index_q;
	logic [OUT_COUNT_BITS-1:0] red_count_q;
	logic [OUT_COUNT_BITS-1:0] green_count_q;
	logic [OUT_COUNT_BITS-1:0] blue_count_q;
	logic [TOTAL_BITS-1:0]     pixel_count_q;

	bank_ctrl_t                bank_ctrl;
	logic [BIN_BITS-1:0]       red_addr;
	logic [BIN_BITS-1:0]       green_addr;
	logic [BIN_BITS-1:0]       blue_addr;
	logic [COUNT_BITS-1:0]     red_cur;
	logic [COUNT_BITS-1:0]     green_cur;
	logic [COUNT_BITS-1:0]     blue_cur;

	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;
	assign accept   = in_valid && advance;
	assign cmd_in   = cmd_t'(cmd);

	always_comb begin
		inc_s1 = 1'b0;
		clr_s1 = 1'b0;
		rd_s1  = 1'b0;
		unique case (cmd_s1)
			CMD_ADD: begin
				inc_s1 = valid_s1;
			end
			CMD_READ: begin
				rd_s1 = valid_s1;
			end
			CMD_CLEAR: begin
				rd_s1  = valid_s1;
				clr_s1 = valid_s1;
			end
			CMD_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// A pixel addresses each bank by its own byte; a read uses the bin index for all three.
	assign red_addr   = (cmd_in == CMD_ADD) ? BIN_BITS'(red_value)   : read_bin;
	assign green_addr = (cmd_in == CMD_ADD) ? BIN_BITS'(green_value) : read_bin;
	assign blue_addr  = (cmd_in == CMD_ADD) ? BIN_BITS'(blue_value)  : read_bin;

	assign bank_ctrl.advance = advance;
	assign bank_ctrl.accept  = accept;
	assign bank_ctrl.s1_inc  = inc_s1 && advance;
	assign bank_ctrl.s1_clr  = clr_s1 && advance;

	rgbh_bank u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bank_ctrl),
		.addr   (red_addr),
		.count  (red_cur)
	);

	rgbh_bank u_green (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bank_ctrl),
		.addr   (green_addr),
		.count  (green_cur)
	);

	rgbh_bank u_blue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bank_ctrl),
		.addr   (blue_addr),
		.count  (blue_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			pixel_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			out_valid_q <= rd_s1;
			if (inc_s1 && (pixel_total_q != TOTAL_MAX)) begin
				pixel_total_q <= pixel_total_q + TOTAL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
			bin_s1 <= read_bin;
		end
		if (advance && rd_s1) begin
			bin_index_q   <= bin_s1;
			red_count_q   <= OUT_COUNT_BITS'(red_cur);
			green_count_q <= OUT_COUNT_BITS'(green_cur);
			blue_count_q  <= OUT_COUNT_BITS'(blue_cur);
			pixel_count_q <= pixel_total_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign bin_index   = bin_index_q;
	assign red_count   = red_count_q;
	assign green_count = green_count_q;
	assign blue_count  = blue_count_q;
	assign pixel_count = pixel_count_q;

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rd_s1 |=> out_valid)
		else $error("read item produced no result");

	a_read_total: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rd_s1 |=> (pixel_count == $past(pixel_total_q)))
		else $error("reported pixel total does not match running total");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_total_q >= $past(pixel_total_q))
		else $error("pixel total decreased");

endmodule

/* sim/rgb_channel_histogram_test.sv */
`timescale 1ns / 1ps

module rgb_channel_histogram_test;
	import rgbh_pkg::*;

	localparam int PIXEL_ITEMS = 1850;
	localparam int IDLE_PCT    = 34;
	localparam int STUCK_LIMIT = 2000;

	typedef struct {
		bit                  pause;
		cmd_t                op;
		logic [7:0]          red;
		logic [7:0]          green;
		logic [7:0]          blue;
		logic [BIN_BITS-1:0] bin;
	} pixel_req_t;

	typedef struct {
		logic [BIN_BITS-1:0]       bin;
		logic [OUT_COUNT_BITS-1:0] red;
		logic [OUT_COUNT_BITS-1:0] green;
		logic [OUT_COUNT_BITS-1:0] blue;
		logic [TOTAL_BITS-1:0]     total;
	} bin_report_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                cmd = '0;
	logic [7:0]                red_value = '0;
	logic [7:0]                green_value = '0;
	logic [7:0]                blue_value = '0;
	logic [BIN_BITS-1:0]       read_bin = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [BIN_BITS-1:0]       bin_index;
	logic [OUT_COUNT_BITS-1:0] red_count;
	logic [OUT_COUNT_BITS-1:0] green_count;
	logic [OUT_COUNT_BITS-1:0] blue_count;
	logic [TOTAL_BITS-1:0]     pixel_count;

	// Local copy of the histogram state.
	logic [COUNT_BITS-1:0] red_hist[BIN_COUNT];
	logic [COUNT_BITS-1:0] green_hist[BIN_COUNT];
	logic [COUNT_BITS-1:0] blue_hist[BIN_COUNT];
	logic [TOTAL_BITS-1:0] pixels_seen;

	pixel_req_t  pending[$];
	bin_report_t reports_due[$];
	logic [7:0]  hot_vals[4];

	bit   in_taken;
	int   inputs_taken;
	int   items_total;
	int   n_add;
	int   n_read;
	int   n_clear;
	int   n_skip;
	int   mismatches;
	int   results_checked;
	int   stuck_cycles;
	int   peak_count;
	logic calm;

	rgb_channel_histogram DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.red_value   (red_value),
		.green_value (green_value),
		.blue_value  (blue_value),
		.read_bin    (read_bin),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bin_index   (bin_index),
		.red_count   (red_count),
		.green_count (green_count),
		.blue_count  (blue_count),
		.pixel_count (pixel_count)
	);

	always #5 clk = ~clk;

	// Both sides run without idling for a stretch in the middle of the run.
	assign calm = (inputs_taken >= 700) && (inputs_taken < 1000);

	task automatic queue_item(input cmd_t op, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [BIN_BITS-1:0] bin);
		pixel_req_t req;
		req.pause = 1'b0;
		req.op    = op;
		req.red   = r;
		req.green = g;
		req.blue  = b;
		req.bin   = bin;
		pending.push_back(req);
		items_total++;
		case (op)
			CMD_ADD: n_add++;
			CMD_READ: n_read++;
			CMD_CLEAR: n_clear++;
			default: n_skip++;
		endcase
	endtask

	// The sender holds off until every outstanding read has come back.
	task automatic queue_pause();
		pixel_req_t req;
		req.pause = 1'b1;
		req.op    = CMD_NONE;
		req.red   = '0;
		req.green = '0;
		req.blue  = '0;
		req.bin   = '0;
		pending.push_back(req);
	endtask

	// Half of the values land on a few hot bins so counts build up and repeat back to back.
	function automatic logic [7:0] pick_value();
		if ($urandom_range(1) == 1)
			return hot_vals[$urandom_range(3)];
		return 8'($urandom());
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin : drive_pixels
		pixel_req_t req;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending.size() != 0 && pending[0].pause) begin
					in_valid <= 1'b0;
					if (reports_due.size() == 0)
						void'(pending.pop_front());
				end else if (pending.size() != 0 &&
						(calm || $urandom_range(99) >= IDLE_PCT)) begin
					req = pending.pop_front();
					cmd         <= req.op;
					red_value   <= req.red;
					green_value <= req.green;
					blue_value  <= req.blue;
					read_bin    <= req.bin;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_ports
		bin_report_t rep;
		cmd_t        op;
		if (!arst_n) begin
			for (int i = 0; i < BIN_COUNT; i++) begin
				red_hist[i]   = '0;
				green_hist[i] = '0;
				blue_hist[i]  = '0;
			end
			pixels_seen  = '0;
			stuck_cycles = 0;
			in_taken    <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				inputs_taken++;
				op = cmd_t'(cmd);
				case (op)
					CMD_ADD: begin
						if (red_hist[red_value] != COUNT_MAX)
							red_hist[red_value] += COUNT_BITS'(1);
						if (green_hist[green_value] != COUNT_MAX)
							green_hist[green_value] += COUNT_BITS'(1);
						if (blue_hist[blue_value] != COUNT_MAX)
							blue_hist[blue_value] += COUNT_BITS'(1);
						if (pixels_seen != TOTAL_MAX)
							pixels_seen += TOTAL_BITS'(1);
					end
					CMD_READ, CMD_CLEAR: begin
						rep.bin   = read_bin;
						rep.red   = red_hist[read_bin];
						rep.green = green_hist[read_bin];
						rep.blue  = blue_hist[read_bin];
						rep.total = pixels_seen;
						reports_due.push_back(rep);
						if (op == CMD_CLEAR) begin
							red_hist[read_bin]   = '0;
							green_hist[read_bin] = '0;
							blue_hist[read_bin]  = '0;
						end
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$error("result for bin %0d with no read outstanding", bin_index);
					mismatches++;
				end else begin
					rep = reports_due.pop_front();
					check_field("bin_index", 32'(rep.bin), 32'(bin_index));
					check_field("red_count", 32'(rep.red), 32'(red_count));
					check_field("green_count", 32'(rep.green), 32'(green_count));
					check_field("blue_count", 32'(rep.blue), 32'(blue_count));
					check_field("pixel_count", rep.total, pixel_count);
					results_checked++;
					if (int'(rep.red) > peak_count)
						peak_count = int'(rep.red);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("no transfer for %0d cycles", STUCK_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int sel;
		int run_len;
		int k;
		logic [7:0] v;

		foreach (hot_vals[j])
			hot_vals[j] = 8'($urandom());

		// Directed part: empty bins, extreme bytes, alternating bit patterns, the unused
		// command, read and clear, and a bin hit several times in a row.
		queue_item(CMD_READ, 8'hff, 8'hff, 8'hff, 8'h00);
		queue_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'hff);
		queue_item(CMD_ADD, 8'h00, 8'h00, 8'h00, 8'hff);
		queue_item(CMD_ADD, 8'hff, 8'hff, 8'hff, 8'h00);
		queue_item(CMD_ADD, 8'h00, 8'hff, 8'haa, 8'h55);
		queue_item(CMD_ADD, 8'haa, 8'h55, 8'haa, 8'h00);
		queue_item(CMD_ADD, 8'h55, 8'haa, 8'h55, 8'h00);
		queue_item(CMD_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
		queue_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'hff);
		queue_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'haa);
		queue_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		repeat (3)
			queue_item(CMD_ADD, 8'h07, 8'h07, 8'h07, 8'h07);
		queue_item(CMD_READ, 8'h07, 8'h07, 8'h07, 8'h07);
		queue_item(CMD_CLEAR, 8'h07, 8'h07, 8'h07, 8'h07);
		queue_item(CMD_READ, 8'h07, 8'h07, 8'h07, 8'h07);
		queue_item(CMD_ADD, 8'h07, 8'h07, 8'h07, 8'h07);
		queue_item(CMD_READ, 8'h07, 8'h07, 8'h07, 8'h07);
		queue_item(CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h07);
		queue_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h55);
		queue_pause();

		k = 0;
		while (items_total < PIXEL_ITEMS) begin
			k++;
			if (k % 150 == 0)
				foreach (hot_vals[j])
					hot_vals[j] = ($urandom_range(9) == 0) ? 8'hff : 8'($urandom());
			if (k % 400 == 0)
				queue_pause();
			sel = $urandom_range(99);
			if (sel < 4) begin
				queue_item(CMD_NONE, 8'($urandom()), 8'($urandom()), 8'($urandom()),
					8'($urandom()));
			end else if (sel < 12) begin
				// A run of identical pixels, then that bin is read straight away.
				v = pick_value();
				run_len = $urandom_range(2, 6);
				repeat (run_len)
					queue_item(CMD_ADD, v, v, v, 8'($urandom()));
				queue_item(($urandom_range(2) == 0) ? CMD_CLEAR : CMD_READ,
					8'($urandom()), 8'($urandom()), 8'($urandom()), v);
			end else if (sel < 66) begin
				queue_item(CMD_ADD, pick_value(), pick_value(), pick_value(), 8'($urandom()));
			end else if (sel < 90) begin
				queue_item(CMD_READ, 8'($urandom()), 8'($urandom()), 8'($urandom()),
					pick_value());
			end else begin
				queue_item(CMD_CLEAR, 8'($urandom()), 8'($urandom()), 8'($urandom()),
					pick_value());
			end
		end

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (inputs_taken < items_total)
			@(negedge clk);
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Covered %0d pixels, %0d reads, %0d read-and-clears, %0d unused commands.",
			n_add, n_read, n_clear, n_skip);
		$display("Checked %0d bin reports; deepest red bin seen held %0d pixels.",
			results_checked, peak_count);
		if (mismatches == 0 && reports_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
